### hw/rtl/elr_pkg.sv
// shared types, constants and the slot reduction function for the error log ring
// no dependencies; imported by every module of the block
package elr_pkg;

    localparam int SLOTS   = 25;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int IDX_W   = 5;
    localparam int COUNT_W = 5;
    // start is below SLOTS, index below 2**IDX_W
    localparam int SUM_W   = $clog2(SLOTS + (1 << IDX_W));
    localparam int MULTS   = (SLOTS - 1 + (1 << IDX_W) - 1) / SLOTS;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_COUNT = 2'd1,
        ACT_GET   = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef struct packed {
        logic [6:0]  code;
        logic [15:0] hours;
        logic [7:0]  minutes;
        logic [7:0]  seconds;
    } entry_t;

    localparam entry_t EMPTY_ENTRY = '1;

    typedef struct packed {
        logic capture;   // latch the accepted beat
        logic exec;      // store access: write on add, read on get
        logic respond;   // load the result register
    } elr_cmd_t;

    typedef struct packed {
        logic out_free;  // result register can take a new beat
    } elr_status_t;

    // (start + idx) mod SLOTS by MULTS (two) independent compares
    function automatic logic [SLOT_W-1:0] slot_mod(
        input logic [SLOT_W-1:0] start,
        input logic [IDX_W-1:0]  idx
    );
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] r;
        sum = SUM_W'(start) + SUM_W'(idx);
        r   = sum;
        for (int k = 1; k <= MULTS; k++)
        begin
            if (sum >= SUM_W'(k * SLOTS))
            begin
                r = sum - SUM_W'(k * SLOTS);
            end
        end
        return r[SLOT_W-1:0];
    endfunction

endpackage

### hw/rtl/elr_ctrl.sv
// sequencer of the error log ring: accept, store access, result
// depends on elr_pkg
module elr_ctrl
    import elr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  elr_status_t status,
    output elr_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   stall_next;

    always_comb
    begin
        cmd.capture = (state_reg == ST_IDLE) && req_valid;
        cmd.exec    = (state_reg == ST_EXEC);
        cmd.respond = (state_reg == ST_RESP) && status.out_free;
        state_next  = state_reg;
        stall_next  = stall_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                    stall_next = 1'b1;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                    stall_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                stall_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    assign req_stall = stall_reg;

endmodule

### hw/rtl/elr_datapath.sv
// datapath of the error log ring: entry store, slot pointer, result register
// depends on elr_pkg
module elr_datapath
    import elr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  elr_cmd_t           cmd,
    output elr_status_t        status,
    input  logic [1:0]         action,
    input  logic [6:0]         err_code,
    input  logic [15:0]        err_hours,
    input  logic [7:0]         err_minutes,
    input  logic [7:0]         err_seconds,
    input  logic [IDX_W-1:0]   entry_index,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [COUNT_W-1:0] entry_count,
    output logic [6:0]         got_code,
    output logic [15:0]        got_hours,
    output logic [7:0]         got_minutes,
    output logic [7:0]         got_seconds
);

    // latched beat
    action_t          action_reg;
    entry_t           item_reg;
    logic [IDX_W-1:0] index_reg;

    // ring state
    logic [SLOT_W-1:0] write_slot_reg;
    logic [SLOT_W-1:0] write_slot_next;
    logic              wrapped_reg;
    logic              wrapped_next;
    logic [SLOTS-1:0]  filled_reg;

    // store and its registered read port
    entry_t            store_mem [SLOTS];
    entry_t            rd_data_reg;
    logic              rd_hit_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic              do_add;
    logic              do_get;

    // result register
    logic               rsp_valid_reg;
    logic [COUNT_W-1:0] count_reg;
    entry_t             got_reg;
    entry_t             got_next;
    logic [COUNT_W-1:0] count_next;

    assign do_add = cmd.exec && (action_reg == ACT_ADD);
    assign do_get = cmd.exec && (action_reg == ACT_GET);
    // oldest entry sits at the write slot once the ring has wrapped
    assign rd_addr = slot_mod(wrapped_reg ? write_slot_reg : '0, index_reg);

    always_comb
    begin
        if (write_slot_reg == SLOT_W'(SLOTS - 1))
        begin
            write_slot_next = '0;
            wrapped_next    = 1'b1;
        end
        else
        begin
            write_slot_next = write_slot_reg + 1'b1;
            wrapped_next    = wrapped_reg;
        end
    end

    always_comb
    begin
        count_next = wrapped_reg ? COUNT_W'(SLOTS) : COUNT_W'(write_slot_reg);
        case (action_reg)
            ACT_GET:
            begin
                got_next = rd_hit_reg ? rd_data_reg : EMPTY_ENTRY;
            end
            default:
            begin
                got_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action_t'(action);
            item_reg   <= '{code: err_code, hours: err_hours,
                            minutes: err_minutes, seconds: err_seconds};
            index_reg  <= entry_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            wrapped_reg    <= 1'b0;
            filled_reg     <= '0;
        end
        else if (do_add)
        begin
            write_slot_reg             <= write_slot_next;
            wrapped_reg                <= wrapped_next;
            filled_reg[write_slot_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_add)
        begin
            store_mem[write_slot_reg] <= item_reg;
        end
        if (do_get)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_hit_reg <= 1'b0;
        end
        else if (do_get)
        begin
            rd_hit_reg <= filled_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.respond)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            count_reg <= count_next;
            got_reg   <= got_next;
        end
    end

    assign status.out_free = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid   = rsp_valid_reg;
    assign entry_count = count_reg;
    assign got_code    = got_reg.code;
    assign got_hours   = got_reg.hours;
    assign got_minutes = got_reg.minutes;
    assign got_seconds = got_reg.seconds;

endmodule

### hw/rtl/error_log_ring_top.sv
// Error log ring: a ring of SLOTS (25) entries, each a 7-bit code with hours,
// minutes and seconds. Every request beat (add, count query, get by age index)
// returns exactly one response beat carrying the filled-entry count after the
// request; a get also returns the entry of that age, age 0 being the oldest, or
// all ones (code 127) for a slot never written. The index wraps modulo SLOTS.
// Add, count and the unused action return zero data fields. One request is
// processed at a time, through these steps from acceptance to the response
// register: accept, one store access on the single-port entry memory, result
// load. A new request is not taken until the last result is loaded, which
// waits while the response beat is held by stall. Reset empties the ring at
// once through per-slot filled bits, so no clearing pass follows.
// Depends on elr_pkg, elr_ctrl and elr_datapath.
module error_log_ring_top
    import elr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         action,
    input  logic [6:0]         err_code,
    input  logic [15:0]        err_hours,
    input  logic [7:0]         err_minutes,
    input  logic [7:0]         err_seconds,
    input  logic [IDX_W-1:0]   entry_index,
    // response channel
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [COUNT_W-1:0] entry_count,
    output logic [6:0]         got_code,
    output logic [15:0]        got_hours,
    output logic [7:0]         got_minutes,
    output logic [7:0]         got_seconds
);

    elr_cmd_t    cmd;
    elr_status_t status;

    // sequencer: one request beat in flight, holds stall until its result is loaded
    elr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // entry store, write slot and wrapped flag, response register
    elr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .action      (action),
        .err_code    (err_code),
        .err_hours   (err_hours),
        .err_minutes (err_minutes),
        .err_seconds (err_seconds),
        .entry_index (entry_index),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .entry_count (entry_count),
        .got_code    (got_code),
        .got_hours   (got_hours),
        .got_minutes (got_minutes),
        .got_seconds (got_seconds)
    );

endmodule

### hw/rtl/elr_checker.sv
// port-level checks of the error log ring, bound to the top level
// depends on elr_pkg and error_log_ring_top
module elr_checker
    import elr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input logic [COUNT_W-1:0] entry_count,
    input logic [6:0]         got_code,
    input logic [15:0]        got_hours,
    input logic [7:0]         got_minutes,
    input logic [7:0]         got_seconds
);

    // a stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(entry_count)
            && $stable(got_code) && $stable(got_hours)
            && $stable(got_minutes) && $stable(got_seconds))
        else $error("stalled response beat changed");

    // one request at a time: acceptance closes the request side
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request side open after acceptance");

    // a new response only comes from a request in flight
    a_rsp_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response without a request in flight");

    // count never exceeds the ring size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> entry_count <= COUNT_W'(SLOTS))
        else $error("entry count beyond ring size");

endmodule

bind error_log_ring_top elr_checker u_elr_checker (.*);

### verif/tb_top.sv
// testbench for error_log_ring_top: directed and random request beats with an
// in-bench ring predictor, bursty sender and patterned response stall
// depends on elr_pkg and the error_log_ring_top rtl
module tb_top;
    import elr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 750;
    // long response hold-off starts once this many requests were taken
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 200;

    typedef struct {
        action_t          act;
        entry_t           data;
        logic [IDX_W-1:0] idx;
        bit               drain_first;  // wait until every response is back
    } log_req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        entry_t             data;
    } log_rsp_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    // request channel, all driven known from time zero
    logic               req_valid = 1'b0;
    logic               req_stall;
    action_t            req_action = ACT_COUNT;
    logic [6:0]         err_code = '0;
    logic [15:0]        err_hours = '0;
    logic [7:0]         err_minutes = '0;
    logic [7:0]         err_seconds = '0;
    logic [IDX_W-1:0]   entry_index = '0;

    // response channel
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic [COUNT_W-1:0] entry_count;
    logic [6:0]         got_code;
    logic [15:0]        got_hours;
    logic [7:0]         got_minutes;
    logic [7:0]         got_seconds;

    // stimulus and expectation queues
    log_req_t pending_reqs[$];
    log_rsp_t expected_rsps[$];

    // predictor state: ring contents, next write slot, wrap flag
    entry_t   ring_store[SLOTS];
    int       ring_wr_slot;
    bit       ring_wrapped;

    int       error_count = 0;
    int       cycle_count = 0;
    int       accepted_reqs = 0;
    bit       req_taken = 1'b0;   // request beat accepted at the last rising edge
    int       hold_left = 0;
    bit       hold_done = 1'b0;

    error_log_ring_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .action      (req_action),
        .err_code    (err_code),
        .err_hours   (err_hours),
        .err_minutes (err_minutes),
        .err_seconds (err_seconds),
        .entry_index (entry_index),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .entry_count (entry_count),
        .got_code    (got_code),
        .got_hours   (got_hours),
        .got_minutes (got_minutes),
        .got_seconds (got_seconds)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ring predictor: apply one request beat, return the response it causes
    function automatic log_rsp_t ring_apply(action_t act, entry_t data, logic [IDX_W-1:0] idx);
        log_rsp_t rsp;
        int       start;
        rsp.data = '0;
        case (act)
            ACT_ADD:
            begin
                ring_store[ring_wr_slot] = data;
                ring_wr_slot = ring_wr_slot + 1;
                if (ring_wr_slot >= SLOTS)
                begin
                    ring_wr_slot = 0;
                    ring_wrapped = 1'b1;
                end
            end
            ACT_GET:
            begin
                // oldest entry is slot 0 until the first wrap, the write slot after
                start = ring_wrapped ? ring_wr_slot : 0;
                rsp.data = ring_store[(start + int'(idx)) % SLOTS];
            end
            default:
            begin
                // count query and the unused action leave the ring alone
            end
        endcase
        rsp.count = COUNT_W'(ring_wrapped ? SLOTS : ring_wr_slot);
        return rsp;
    endfunction

    task automatic check_field(string name, int want, int seen);
        if (want != seen)
        begin
            $error("%s: expected %0d, actual %0d", name, want, seen);
            error_count++;
        end
    endtask

    task automatic push_req(action_t act, logic [6:0] code, logic [15:0] hours,
                            logic [7:0] minutes, logic [7:0] seconds,
                            logic [IDX_W-1:0] idx, bit drain_first);
        log_req_t r;
        r.act          = act;
        r.data.code    = code;
        r.data.hours   = hours;
        r.data.minutes = minutes;
        r.data.seconds = seconds;
        r.idx          = idx;
        r.drain_first  = drain_first;
        pending_reqs.push_back(r);
    endtask

    // sender: bursts of random length separated by random gaps
    always @(negedge clk)
    begin : req_driver
        static int burst_left = 8;
        static int gap_left = 0;
        log_req_t  r;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (req_valid && !req_taken)
        begin
            // beat still stalled, payload holds
        end
        else if (gap_left > 0)
        begin
            req_valid <= 1'b0;
            gap_left = gap_left - 1;
        end
        else if (pending_reqs.size() == 0 ||
                 (pending_reqs[0].drain_first && expected_rsps.size() != 0))
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            r = pending_reqs.pop_front();
            req_valid   <= 1'b1;
            req_action  <= r.act;
            err_code    <= r.data.code;
            err_hours   <= r.data.hours;
            err_minutes <= r.data.minutes;
            err_seconds <= r.data.seconds;
            entry_index <= r.idx;
            if (burst_left <= 1)
            begin
                burst_left = $urandom_range(1, 40);
                // mostly short gaps, sometimes long ones, often none
                gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                        : $urandom_range(0, 4);
            end
            else
            begin
                burst_left = burst_left - 1;
            end
        end
    end

    // long hold-off of the response side, counted here in cycles
    always @(posedge clk)
    begin
        if (!hold_done && accepted_reqs >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver: stall pattern that changes mode every segment
    always @(negedge clk)
    begin : rsp_stall_gen
        static int seg_left = 0;
        static int seg_mode = 0;
        logic      s;
        if (seg_left == 0)
        begin
            seg_mode = $urandom_range(0, 3);
            seg_left = $urandom_range(20, 120);
        end
        seg_left = seg_left - 1;
        case (seg_mode)
            0:       s = 1'b0;                           // no stall at all
            1:       s = ($urandom_range(0, 3) == 0);    // light
            2:       s = ($urandom_range(0, 3) != 0);    // heavy
            default: s = ~rsp_stall;                     // alternate
        endcase
        rsp_stall <= (hold_left != 0) || s;
    end

    // monitor: predict on each request beat, check each response beat
    always @(posedge clk)
    begin : monitor
        log_rsp_t want;
        entry_t   req_data;
        if (rst_n)
        begin
            req_taken <= req_valid && !req_stall;
            if (req_valid && !req_stall)
            begin
                req_data = {err_code, err_hours, err_minutes, err_seconds};
                expected_rsps.push_back(ring_apply(req_action, req_data, entry_index));
                accepted_reqs <= accepted_reqs + 1;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("response beat with no request outstanding");
                    error_count++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    check_field("entry_count", want.count, entry_count);
                    check_field("got_code", want.data.code, got_code);
                    check_field("got_hours", want.data.hours, got_hours);
                    check_field("got_minutes", want.data.minutes, got_minutes);
                    check_field("got_seconds", want.data.seconds, got_seconds);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : main
        int      sel;
        action_t act;
        entry_t  d;
        for (int i = 0; i < SLOTS; i++)
        begin
            ring_store[i] = EMPTY_ENTRY;
        end
        ring_wr_slot = 0;
        ring_wrapped = 1'b0;

        // directed: empty ring reads, unused action, data extremes,
        // code 127 written like an empty slot, index past the filled entries
        push_req(ACT_COUNT, 7'd0, 16'd0, 8'd0, 8'd0, 5'd0, 1'b0);
        push_req(ACT_GET, 7'd0, 16'd0, 8'd0, 8'd0, 5'd0, 1'b0);
        push_req(ACT_GET, 7'd0, 16'd0, 8'd0, 8'd0, 5'd24, 1'b0);
        push_req(ACT_NONE, 7'd127, 16'hffff, 8'hff, 8'hff, 5'd24, 1'b0);
        push_req(ACT_ADD, 7'd0, 16'd0, 8'd0, 8'd0, 5'd0, 1'b0);
        push_req(ACT_ADD, 7'd127, 16'hffff, 8'hff, 8'hff, 5'd24, 1'b0);
        push_req(ACT_ADD, 7'd85, 16'h5a5a, 8'ha5, 8'h3c, 5'd7, 1'b0);
        push_req(ACT_COUNT, 7'd127, 16'hffff, 8'hff, 8'hff, 5'd24, 1'b0);
        push_req(ACT_GET, 7'd0, 16'd0, 8'd0, 8'd0, 5'd0, 1'b0);
        push_req(ACT_GET, 7'd0, 16'd0, 8'd0, 8'd0, 5'd1, 1'b0);
        push_req(ACT_GET, 7'd0, 16'd0, 8'd0, 8'd0, 5'd2, 1'b0);
        push_req(ACT_GET, 7'd0, 16'd0, 8'd0, 8'd0, 5'd3, 1'b0);
        push_req(ACT_GET, 7'd0, 16'd0, 8'd0, 8'd0, 5'd24, 1'b0);
        push_req(ACT_GET, 7'd127, 16'hffff, 8'hff, 8'hff, 5'd7, 1'b0);
        push_req(ACT_NONE, 7'd42, 16'h1234, 8'h56, 8'h78, 5'd5, 1'b0);
        push_req(ACT_COUNT, 7'd0, 16'd0, 8'd0, 8'd0, 5'd0, 1'b0);
        push_req(ACT_ADD, 7'd42, 16'h8001, 8'h7f, 8'h80, 5'd16, 1'b0);
        push_req(ACT_GET, 7'd0, 16'd0, 8'd0, 8'd0, 5'd3, 1'b0);
        push_req(ACT_GET, 7'd0, 16'd0, 8'd0, 8'd0, 5'd8, 1'b0);

        // random: mostly adds and gets so the ring wraps many times
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                act = ACT_ADD;
            else if (sel < 85)
                act = ACT_GET;
            else if (sel < 95)
                act = ACT_COUNT;
            else
                act = ACT_NONE;
            if ($urandom_range(0, 9) == 0)
            begin
                d = ($urandom_range(0, 1) == 0) ? entry_t'('0) : EMPTY_ENTRY;
            end
            else
            begin
                d.code    = 7'($urandom_range(0, 127));
                d.hours   = 16'($urandom);
                d.minutes = 8'($urandom);
                d.seconds = 8'($urandom);
            end
            // a few points where the sender waits for every response
            push_req(act, d.code, d.hours, d.minutes, d.seconds,
                     IDX_W'($urandom_range(0, SLOTS - 1)),
                     (i == 200) || (i == 500) || ($urandom_range(0, 99) == 0));
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for all beats sent and all responses back; the sender only
        // moves at the falling edge, so its state is settled here
        do
        begin
            @(posedge clk);
        end
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
